// ===== sv/tsba_pkg.sv =====
package tsba_pkg;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned SIZE_W  = 31;
   localparam int unsigned ALIGN_W = 12;

   localparam logic [ALIGN_W-1:0] ALIGN_16  = 12'h010;
   localparam logic [ALIGN_W-1:0] ALIGN_64  = 12'h040;
   localparam logic [ALIGN_W-1:0] ALIGN_256 = 12'h100;
   localparam logic [ALIGN_W-1:0] ALIGN_DEFAULT = ALIGN_16;

   typedef enum logic {
      CSR_HEAP_BASE = 1'b0,
      CSR_HEAP_SIZE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  alloc_size;
      logic               from_top;
      logic [ALIGN_W-1:0] align_bytes;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] block_address;
      logic              alloc_failed;
      logic [ADDR_W-1:0] bottom_used;
      logic [ADDR_W-1:0] bottom_next;
      logic [ADDR_W-1:0] top_next;
   } calc_type;

endpackage

// ===== sv/tsba_calc.sv =====
module tsba_calc
   import tsba_pkg::*;
(
   input  req_type           req,
   input  logic [ADDR_W-1:0] bottom_ptr,
   input  logic [ADDR_W-1:0] top_ptr,
   input  logic [ADDR_W-1:0] heap_base,
   output calc_type          result
);

   logic [ADDR_W-1:0]  round_mask;
   logic [ADDR_W:0]    bot_start;
   logic [ADDR_W+1:0]  bot_end;
   logic               bot_fail;
   logic [ALIGN_W-1:0] top_align;
   logic [ADDR_W-1:0]  top_mask;
   logic [ADDR_W-1:0]  top_start;
   logic               top_fail;
   logic               size_zero;

   always_comb begin
      case (req.align_bytes)
         ALIGN_64:  round_mask = ADDR_W'(ALIGN_64) - ADDR_W'(1);
         ALIGN_256: round_mask = ADDR_W'(ALIGN_256) - ADDR_W'(1);
         default:   round_mask = ADDR_W'(ALIGN_16) - ADDR_W'(1);
      endcase
   end

   assign size_zero = (req.alloc_size == '0);

   // The bottom end rounds and adds without wrapping so that an overrun fails.
   assign bot_start = ({1'b0, bottom_ptr} + {1'b0, round_mask}) & ~{1'b0, round_mask};
   assign bot_end   = {1'b0, bot_start} + (ADDR_W+2)'(req.alloc_size);
   assign bot_fail  = bot_end > {2'b00, top_ptr};

   assign top_align = (req.align_bytes == '0) ? ALIGN_DEFAULT : req.align_bytes;
   assign top_mask  = ADDR_W'(0) - ADDR_W'(top_align);
   assign top_start = (top_ptr - ADDR_W'(req.alloc_size)) & top_mask;
   assign top_fail  = (ADDR_W'(req.alloc_size) > top_ptr) || (bottom_ptr >= top_start);

   always_comb begin
      result.block_address = '0;
      result.alloc_failed  = 1'b0;
      result.bottom_next   = bottom_ptr;
      result.top_next      = top_ptr;
      if (!req.from_top) begin
         if (size_zero) begin
            result.block_address = bot_start[ADDR_W-1:0];
         end else if (bot_fail) begin
            result.alloc_failed = 1'b1;
         end else begin
            result.block_address = bot_start[ADDR_W-1:0];
            result.bottom_next   = bot_end[ADDR_W-1:0];
         end
      end else begin
         if (size_zero) begin
            result.block_address = top_ptr & top_mask;
         end else if (top_fail) begin
            result.alloc_failed = 1'b1;
         end else begin
            result.block_address = top_start;
            result.top_next      = top_start;
         end
      end
      result.bottom_used = result.bottom_next - heap_base;
   end

endmodule

// ===== sv/two_sided_bump_allocator.sv =====
// Heap allocator that hands out blocks from both ends of one region and never frees them.
// Writing either heap register puts the bottom pointer at the base and the top pointer at
// base plus size, saturated at the top of the address space. A request word is registered
// on acceptance and its result word is then written to an output register; the
// pointers update at that same edge, so a new request is accepted every cycle while the
// result side does not stall. Requests stall only while a result word is held by the
// result side.
module two_sided_bump_allocator
   import tsba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [ADDR_W-1:0]  csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [SIZE_W-1:0]  req_alloc_size,
   input  logic               req_from_top,
   input  logic [ALIGN_W-1:0] req_align_bytes,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ADDR_W-1:0]  rsp_block_address,
   output logic               rsp_alloc_failed,
   output logic [ADDR_W-1:0]  rsp_bottom_used
);

   logic              in_valid_ff, in_valid_in;
   req_type           in_word_ff, in_word_in;
   logic              out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0] out_address_ff, out_address_in;
   logic              out_failed_ff, out_failed_in;
   logic [ADDR_W-1:0] out_used_ff, out_used_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] bottom_ff, bottom_in;
   logic [ADDR_W-1:0] top_ff, top_in;
   logic              advance;
   logic              req_take;
   logic              csr_hit;
   logic [ADDR_W:0]   heap_end;
   calc_type          calc;

   tsba_calc u_calc (
      .req        (in_word_ff),
      .bottom_ptr (bottom_ff),
      .top_ptr    (top_ff),
      .heap_base  (base_ff),
      .result     (calc)
   );

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      base_in = base_ff;
      size_in = size_ff;
      csr_hit = 1'b0;
      if (csr_write) begin
         csr_hit = 1'b1;
         case (csr_index_type'(csr_index))
            CSR_HEAP_BASE: base_in = csr_wdata;
            CSR_HEAP_SIZE: size_in = csr_wdata[SIZE_W-1:0];
            default:       csr_hit = 1'b0;
         endcase
      end
   end

   assign heap_end = {1'b0, base_in} + (ADDR_W+1)'(size_in);

   always_comb begin
      in_valid_in    = in_valid_ff;
      in_word_in     = in_word_ff;
      out_valid_in   = out_valid_ff;
      out_address_in = out_address_ff;
      out_failed_in  = out_failed_ff;
      out_used_in    = out_used_ff;
      bottom_in      = bottom_ff;
      top_in         = top_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         in_valid_in  = req_take;
         if (in_valid_ff) begin
            out_address_in = calc.block_address;
            out_failed_in  = calc.alloc_failed;
            out_used_in    = calc.bottom_used;
            bottom_in      = calc.bottom_next;
            top_in         = calc.top_next;
         end
      end
      if (req_take) begin
         in_valid_in            = 1'b1;
         in_word_in.alloc_size  = req_alloc_size;
         in_word_in.from_top    = req_from_top;
         in_word_in.align_bytes = req_align_bytes;
      end
      if (csr_hit) begin
         bottom_in = base_in;
         top_in    = heap_end[ADDR_W] ? '1 : heap_end[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         base_ff      <= '0;
         size_ff      <= '0;
         bottom_ff    <= '0;
         top_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         base_ff      <= base_in;
         size_ff      <= size_in;
         bottom_ff    <= bottom_in;
         top_ff       <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff     <= in_word_in;
      out_address_ff <= out_address_in;
      out_failed_ff  <= out_failed_in;
      out_used_ff    <= out_used_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_block_address = out_address_ff;
   assign rsp_alloc_failed  = out_failed_ff;
   assign rsp_bottom_used   = out_used_ff;

endmodule

// ===== sv/tsba_checker.sv =====
module tsba_checker
   import tsba_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [ADDR_W-1:0]  rsp_block_address,
   input logic               rsp_alloc_failed,
   input logic [ADDR_W-1:0]  rsp_bottom_used
);

   // A failed word never carries an address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alloc_failed |-> rsp_block_address == '0)
      else $error("failed allocation shows a nonzero address");

   // No result word can appear right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_block_address)
         && $stable(rsp_alloc_failed) && $stable(rsp_bottom_used))
      else $error("stalled result word changed");

   // With an empty output side, a request is never refused.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while output is empty");

endmodule

bind two_sided_bump_allocator tsba_checker u_tsba_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_block_address (rsp_block_address),
   .rsp_alloc_failed  (rsp_alloc_failed),
   .rsp_bottom_used   (rsp_bottom_used)
);
